@@ rtl/sliding_window_max_core_defines.svh @@
// Assertion helpers used by the core RTL file.
`ifndef SLIDING_WINDOW_MAX_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MAX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/swm_pkg.sv @@
`timescale 1ns / 1ps
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int DATA_WIDTH = 32;
  localparam int SIZE_W     = 7;
  localparam int AW         = $clog2(WINDOW_MAX);
  localparam int CW         = AW + 1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [AW-1:0]                addr_t;
  typedef logic [CW-1:0]                cnt_t;
  typedef logic [SIZE_W-1:0]            size_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FRONT = 5'b00010,
    S_POP   = 5'b00100,
    S_PUSH  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

@@ rtl/swm_ram.sv @@
`timescale 1ns / 1ps
module swm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sliding_window_max_core.sv @@
`timescale 1ns / 1ps
// Flow: an accepted sample steps through S_FRONT, then S_POP for its back compares (entries popped,
// plus one unless the queue runs empty), then S_PUSH, and S_OUT when a result is due.
// A new sample is taken only in S_IDLE, once the last one is done; the back compares run one
// after another on the single read port of the candidate memory. A stalled result holds input.
// Reset: synchronous, clears queue, ring pointer, sample count and result valid;
// window_size returns to 3. Memories are not cleared.
`include "sliding_window_max_core_defines.svh"
module sliding_window_max_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_wdata,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  logic signed [31:0]    sample,
  input  logic                  frame_start,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic signed [31:0]    window_max
);
  import swm_pkg::*;

  state_t state, state_next;
  size_t  win_size;
  data_t  x;
  addr_t  head, head_next;
  cnt_t   count, count_next;
  addr_t  ptr;
  cnt_t   seen;
  logic   front_is_x;
  logic   res_valid;
  data_t  res_data;

  logic   accept;
  logic   size_bad;
  addr_t  head_eff, ptr_eff;
  cnt_t   count_eff, seen_eff;
  logic   cand_re, cand_we, ring_re, ring_we;
  addr_t  cand_raddr, cand_waddr, ring_raddr;
  data_t  cand_rd, ring_rd;
  logic   drop, gt, full, out_free;
  cnt_t   seen_new;
  logic   has_result;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign size_bad     = (win_size == '0) || (int'(win_size) > WINDOW_MAX);
  assign out_free     = !res_valid || result_ready;
  assign result_valid = res_valid;
  assign window_max   = res_data;

  assign head_eff  = frame_start ? '0 : head;
  assign count_eff = frame_start ? '0 : count;
  assign ptr_eff   = frame_start ? '0 : ptr;
  assign seen_eff  = frame_start ? '0 : seen;

  assign drop = (CW'(seen) >= CW'(win_size)) && (count != '0) && (cand_rd == ring_rd);
  assign gt   = (x > cand_rd);
  assign full = (int'(count) >= WINDOW_MAX);
  assign seen_new   = (CW'(seen) < CW'(win_size)) ? CW'(seen + CW'(1)) : seen;
  assign has_result = (CW'(seen_new) >= CW'(win_size));

  assign ring_re    = accept && !size_bad;
  assign ring_raddr = AW'(ptr_eff - win_size[AW-1:0]);
  assign ring_we    = (state == S_PUSH);
  assign cand_waddr = AW'(head_next + count_next[AW-1:0]);
  assign cand_we    = (state == S_PUSH);

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    cand_re    = 1'b0;
    cand_raddr = head;
    unique case (state)
      S_IDLE: begin
        cand_raddr = head_eff;
        if (accept) begin
          head_next  = head_eff;
          count_next = count_eff;
          if (!size_bad) begin
            cand_re    = 1'b1;
            state_next = S_FRONT;
          end
        end
      end
      S_FRONT: begin
        head_next  = AW'(head + AW'(drop));
        count_next = CW'(count - CW'(drop));
        cand_raddr = AW'(head_next + count_next[AW-1:0] - AW'(1));
        if (count_next != '0) begin
          cand_re    = 1'b1;
          state_next = S_POP;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_POP: begin
        if (gt) begin
          count_next = CW'(count - CW'(1));
          cand_raddr = AW'(head + count_next[AW-1:0] - AW'(1));
          if (count_next != '0) begin
            cand_re = 1'b1;
          end else begin
            state_next = S_PUSH;
          end
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        head_next  = AW'(head + AW'(full));
        count_next = CW'(count - CW'(full));
        cand_raddr = head_next;
        cand_re    = has_result;
        state_next = has_result ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      win_size   <= SIZE_W'(3);
      head       <= '0;
      count      <= '0;
      ptr        <= '0;
      seen       <= '0;
      res_valid  <= 1'b0;
      front_is_x <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      if (cfg_we) begin
        win_size <= cfg_wdata;
      end
      if (state == S_PUSH) begin
        count      <= CW'(count_next + CW'(1));
        front_is_x <= (count_next == '0);
        ptr        <= AW'(ptr + AW'(1));
        seen       <= seen_new;
      end else begin
        count <= count_next;
      end
      if (accept) begin
        ptr  <= ptr_eff;
        seen <= seen_eff;
      end
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (result_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x <= sample;
    end
    if (state == S_OUT && out_free) begin
      res_data <= front_is_x ? x : cand_rd;
    end
  end

  swm_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (DATA_WIDTH)
  ) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .waddr (cand_waddr),
    .wdata (x),
    .re    (cand_re),
    .raddr (cand_raddr),
    .rdata (cand_rd)
  );

  swm_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (DATA_WIDTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr),
    .wdata (x),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rd)
  );

  `SWM_ASSERT_IMP(a_count_bound, 1'b1, int'(count) <= WINDOW_MAX, "candidate count over depth")
  `SWM_ASSERT_IMP(a_pop_nonempty, state == S_POP, count != '0, "pop on empty queue")
  `SWM_ASSERT_NXT(a_out_load, state == S_OUT && out_free, result_valid, "result beat not loaded")
  `SWM_ASSERT_NXT(a_push_grows, state == S_PUSH, count != '0, "queue empty after push")

endmodule

@@ verif/window_max_checker.sv @@
`timescale 1ns / 1ps
module window_max_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  swm_pkg::size_t  cfg_wdata,
  input  logic            sample_valid,
  input  logic            sample_ready,
  input  swm_pkg::data_t  sample,
  input  logic            frame_start,
  input  logic            result_valid,
  input  logic            result_ready,
  input  swm_pkg::data_t  window_max,
  output int              mismatches,
  output int              outstanding
);
  import swm_pkg::*;

  localparam size_t WINDOW_AFTER_RESET = 7'd3;

  size_t window_len;
  data_t cand_val [WINDOW_MAX];
  data_t ring_val [WINDOW_MAX];
  int    cand_head;
  int    cand_cnt;
  int    ring_wr;
  int    seen_cnt;
  int    err_cnt = 0;
  data_t expected_max_q [$];

  function automatic void clear_window();
    cand_head = 0;
    cand_cnt  = 0;
    ring_wr   = 0;
    seen_cnt  = 0;
  endfunction

  function automatic bit advance_window(input data_t x, input logic fs, output data_t top);
    int k;
    int old_slot;
    top = '0;
    if (fs) clear_window();
    if (window_len == 0 || window_len > WINDOW_MAX) return 1'b0;
    k = int'(window_len);
    // drop the sample leaving the window if it still heads the queue
    if (seen_cnt >= k) begin
      old_slot = (ring_wr + WINDOW_MAX - k) % WINDOW_MAX;
      if (cand_cnt > 0 && cand_val[cand_head] == ring_val[old_slot]) begin
        cand_head = (cand_head + 1) % WINDOW_MAX;
        cand_cnt--;
      end
    end
    while (cand_cnt > 0 && x > cand_val[(cand_head + cand_cnt - 1) % WINDOW_MAX])
      cand_cnt--;
    if (cand_cnt >= WINDOW_MAX) begin
      cand_head = (cand_head + 1) % WINDOW_MAX;
      cand_cnt--;
    end
    cand_val[(cand_head + cand_cnt) % WINDOW_MAX] = x;
    cand_cnt++;
    ring_val[ring_wr] = x;
    ring_wr = (ring_wr + 1) % WINDOW_MAX;
    if (seen_cnt < k) seen_cnt++;
    top = cand_val[cand_head];
    return seen_cnt >= k;
  endfunction

  always @(posedge clk) begin : track
    data_t want;
    data_t top;
    if (rst) begin
      window_len = WINDOW_AFTER_RESET;
      clear_window();
      expected_max_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_max_q.size() == 0) begin
          err_cnt++;
          $display("%0t: window_max expected none, actual %0d", $time, window_max);
        end else begin
          want = expected_max_q[0];
          expected_max_q.delete(0);
          if (window_max !== want) begin
            err_cnt++;
            $display("%0t: window_max expected %0d, actual %0d", $time, want, window_max);
          end
        end
      end
      if (sample_valid && sample_ready) begin
        if (advance_window(sample, frame_start, top))
          expected_max_q.insert(expected_max_q.size(), top);
      end
      if (cfg_we) window_len = cfg_wdata;
    end
    outstanding <= expected_max_q.size();
    mismatches  <= err_cnt;
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import swm_pkg::*;

  localparam data_t MAX_S  = data_t'(32'h7fff_ffff);
  localparam data_t MIN_S  = data_t'(32'h8000_0000);
  localparam int    DRAIN  = 200;
  localparam int    HOLD   = 600;
  localparam int    PHASES = 20;

  typedef enum int {K_RANDOM, K_NARROW, K_RISING, K_FALLING, K_EXTREME} run_kind_t;

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  cfg_we       = 1'b0;
  size_t cfg_wdata    = '0;
  logic  sample_valid = 1'b0;
  data_t sample       = '0;
  logic  frame_start  = 1'b0;
  logic  result_ready = 1'b0;
  logic  sample_ready;
  logic  result_valid;
  data_t window_max;
  int    mismatches;
  int    outstanding;
  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    hold_left     = 0;
  logic  hold_start    = 1'b0;

  size_t window_plan [PHASES] = '{7'd64, 7'd13, 7'd1, 7'd4, 7'd0, 7'd64, 7'd31, 7'd2,
                                  7'd100, 7'd8, 7'd64, 7'd3, 7'd65, 7'd24, 7'd127, 7'd5,
                                  7'd64, 7'd40, 7'd1, 7'd9};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sliding_window_max_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .frame_start  (frame_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .window_max   (window_max)
  );

  window_max_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .frame_start  (frame_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .window_max   (window_max),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    result_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_sample(input data_t v, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= v;
    frame_start  <= fs;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_window(input size_t w);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic data_t next_value(input run_kind_t kind, input data_t prev);
    case (kind)
      K_RANDOM:  return data_t'($urandom);
      K_NARROW:  return data_t'($urandom_range(6)) - 3;
      K_RISING:  return prev + data_t'($urandom_range(1000, 1));
      K_FALLING: return prev - data_t'($urandom_range(1000));
      default: begin
        case ($urandom_range(5))
          0:       return MAX_S;
          1:       return MIN_S;
          2:       return '0;
          3:       return -1;
          4:       return MAX_S - 1;
          default: return MIN_S + 1;
        endcase
      end
    endcase
  endfunction

  task automatic run_burst(input run_kind_t kind, input int len, input logic fresh,
                           inout data_t prev);
    for (int i = 0; i < len; i++) begin
      prev = next_value(kind, prev);
      push_sample(prev, fresh && i == 0);
    end
  endtask

  initial begin : stimulus
    data_t     last;
    int        left;
    int        len;
    logic      carry_ramp;
    run_kind_t kind;
    last       = '0;
    carry_ramp = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    push_sample(MAX_S, 1'b1);
    push_sample(MIN_S, 1'b0);
    push_sample('0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(MIN_S, 1'b1);
    push_sample(MIN_S, 1'b0);
    push_sample(MIN_S, 1'b0);
    write_window(7'd1);
    push_sample(MAX_S, 1'b0);
    push_sample(MIN_S, 1'b0);
    push_sample(-1, 1'b1);
    write_window(7'd0);
    push_sample(7, 1'b0);
    push_sample(9, 1'b1);
    write_window(7'd127);
    push_sample(11, 1'b0);
    write_window(7'd4);
    push_sample(1, 1'b0);
    push_sample(2, 1'b0);
    push_sample(3, 1'b0);
    push_sample(4, 1'b0);
    write_window(7'd2);
    push_sample(0, 1'b0);
    push_sample(-5, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      write_window(window_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 71; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 71; end
        default: begin send_idle_pct = 35; stall_pct <= 35; end
      endcase
      // hold the result channel off so the core backs up
      if (p == 2) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      left = (window_plan[p] == 0 || window_plan[p] > WINDOW_MAX) ? 20 : 90;
      while (left > 0) begin
        kind = carry_ramp ? K_FALLING : run_kind_t'($urandom_range(K_EXTREME));
        len  = $urandom_range(2 * int'(window_plan[p]) + 8, 1);
        if (len > left) len = left;
        run_burst(kind, len, !carry_ramp && $urandom_range(3) != 0, last);
        carry_ramp = 1'b0;
        left -= len;
      end
      // fill the candidate queue, then shrink the window mid-sequence
      if (window_plan[p] == WINDOW_MAX) begin
        last = data_t'(32'h4000_0000);
        run_burst(K_FALLING, 70, 1'b1, last);
        carry_ramp = 1'b1;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
